// ----- sv/vortex_particle_velocity_sum_core_defines.svh -----
// Assertion helpers used by the top RTL file of the velocity sum core.
`ifndef VORTEX_PARTICLE_VELOCITY_SUM_CORE_DEFINES_SVH
`define VORTEX_PARTICLE_VELOCITY_SUM_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/vps_pkg.sv -----
package vps_pkg;

	localparam int FRAC_BITS = 16;
	localparam logic [29:0] KGAIN = 30'd683565276;
	localparam int KGAIN_SHIFT = 30;
	localparam logic [40:0] CONTRIB_CLAMP = 41'h100_0000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_ROOT,
		ST_CRS,
		ST_MR,
		ST_DIV1,
		ST_MD,
		ST_DIV2,
		ST_MK,
		ST_FIN,
		ST_ACC
	} vps_state_t;

	typedef struct packed {
		logic signed [32:0] a;
		logic signed [32:0] b;
	} vps_mul_req_t;

endpackage

// ----- sv/vps_if.sv -----
interface vps_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] query_x;
	logic signed [31:0] query_y;
	logic signed [31:0] query_z;
	logic signed [31:0] particle_x;
	logic signed [31:0] particle_y;
	logic signed [31:0] particle_z;
	logic signed [31:0] spin_x;
	logic signed [31:0] spin_y;
	logic signed [31:0] spin_z;
	logic [30:0] core_radius;
	logic first;

	modport source (
		output valid, query_x, query_y, query_z, particle_x, particle_y, particle_z,
		output spin_x, spin_y, spin_z, core_radius, first,
		input ready
	);
	modport sink (
		input valid, query_x, query_y, query_z, particle_x, particle_y, particle_z,
		input spin_x, spin_y, spin_z, core_radius, first,
		output ready
	);
endinterface

interface vps_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] sum_x;
	logic signed [31:0] sum_y;
	logic signed [31:0] sum_z;

	modport source (output valid, sum_x, sum_y, sum_z, input ready);
	modport sink (input valid, sum_x, sum_y, sum_z, output ready);
endinterface

// ----- sv/vps_mul.sv -----
module vps_mul (
	input  logic                  clk,
	input  vps_pkg::vps_mul_req_t req,
	output logic signed [65:0]    prod_q
);
	import vps_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= 66'(req.a * req.b);
	end
endmodule

// ----- sv/vortex_particle_velocity_sum_core.sv -----
// Vortex particle velocity accumulator. Each input word carries a query point and one vortex
// particle; the block adds the particle's smoothed Biot-Savart velocity to a running, saturating
// Q16.16 sum and returns the updated sum as one output word (first restarts the sum). All work
// runs on one registered 33x33 signed multiplier, one bit-serial square root and one
// one-bit-per-cycle 128/64 divider under a sequencer, one item at a time. The 64-step divisions
// take most of an item's time; a query point outside the core needs two per axis, one inside it,
// and a division that saturates ends at its first step. The next input word is taken while a
// finished sum still waits on the output.
`include "vortex_particle_velocity_sum_core_defines.svh"
module vortex_particle_velocity_sum_core (
	input  logic clk,
	input  logic arst_n,
	vps_in_if.sink item,
	vps_out_if.source result
);
	import vps_pkg::*;

	vps_state_t state_q, state_d;
	logic [5:0] cnt_q;
	logic [1:0] axis_q;
	logic first_q;
	logic out_vld_q;
	logic signed [31:0] sum_q [3];

	logic signed [31:0] d_q [3];
	logic signed [31:0] w_q [3];
	logic [30:0] r_q;
	logic [63:0] d2_q, r2_q;
	logic inside_q;
	logic [63:0] rv_q, res_q, bit_q;
	logic [31:0] s_q;
	logic signed [65:0] ca_q;
	logic [63:0] opa_q, opb_q, den_q;
	logic [127:0] acc_q;
	logic neg_q;
	logic signed [41:0] add_q [3];

	vps_mul_req_t mul_req;
	logic signed [65:0] prod_q;

	vps_mul u_mul (.clk(clk), .req(mul_req), .prod_q(prod_q));

	// Index helpers for the cross product of the current axis.
	logic [1:0] ax_n1, ax_n2;
	assign ax_n1 = (axis_q == 2'd2) ? 2'd0 : 2'(axis_q + 2'd1);
	assign ax_n2 = (axis_q == 2'd0) ? 2'd2 : 2'(axis_q - 2'd1);

	// Offsets, saturated to 32 bits.
	logic signed [31:0] d_in [3];
	logic signed [31:0] q_in [3];
	logic signed [31:0] p_in [3];
	assign q_in[0] = item.query_x;
	assign q_in[1] = item.query_y;
	assign q_in[2] = item.query_z;
	assign p_in[0] = item.particle_x;
	assign p_in[1] = item.particle_y;
	assign p_in[2] = item.particle_z;
	for (genvar g = 0; g < 3; g++) begin : g_off
		logic signed [32:0] diff;
		assign diff = 33'(q_in[g]) - 33'(p_in[g]);
		assign d_in[g] = (diff[32] != diff[31]) ?
			(diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : diff[31:0];
	end

	// Partial product accumulation for the 64x64 multiply sequences.
	logic [1:0] k_prev;
	logic [127:0] part_sh, acc_nxt;
	logic mul_st;
	assign mul_st = (state_q == ST_MR) || (state_q == ST_MD) || (state_q == ST_MK);
	assign k_prev = 2'(cnt_q - 6'd1);
	always_comb begin
		part_sh = {64'd0, prod_q[63:0]};
		case (k_prev)
			2'd0: part_sh = {64'd0, prod_q[63:0]};
			2'd3: part_sh = {prod_q[63:0], 64'd0};
			default: part_sh = {32'd0, prod_q[63:0], 32'd0};
		endcase
	end
	assign acc_nxt = acc_q + part_sh;

	// Square root step.
	logic [63:0] root_sum, root_res;
	logic root_ge;
	assign root_sum = res_q + bit_q;
	assign root_ge = rv_q >= root_sum;
	assign root_res = root_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	// Restoring divider step on {remainder, dividend}.
	logic [64:0] rem2, rem_sub;
	logic div_ge, div_sat;
	logic [127:0] div_nxt;
	assign rem2 = {acc_q[127:64], acc_q[63]};
	assign rem_sub = rem2 - {1'b0, den_q};
	assign div_ge = rem2 >= {1'b0, den_q};
	assign div_nxt = {div_ge ? rem_sub[63:0] : rem2[63:0], acc_q[62:0], div_ge};
	assign div_sat = (den_q == 64'd0) || (acc_q[127:64] >= den_q);
	logic div_st, div_done;
	assign div_st = (state_q == ST_DIV1) || (state_q == ST_DIV2);
	assign div_done = ((cnt_q == 6'd0) && div_sat) || (cnt_q == 6'd63);
	logic [63:0] div_t;
	assign div_t = ((cnt_q == 6'd0) && div_sat) ? '1 : div_nxt[63:0];

	// Cross component difference.
	logic signed [66:0] crs_diff;
	logic [63:0] crs_mag;
	assign crs_diff = 67'(ca_q) - 67'(prod_q);
	assign crs_mag = crs_diff[66] ? 64'(-crs_diff) : 64'(crs_diff);

	// Scaled contribution magnitude.
	logic [63:0] v_raw;
	logic [40:0] v_mag;
	assign v_raw = acc_q[KGAIN_SHIFT +: 64];
	assign v_mag = ((|acc_q[127:KGAIN_SHIFT + 64]) || (v_raw > 64'(CONTRIB_CLAMP))) ?
		CONTRIB_CLAMP : v_raw[40:0];

	logic acc_fire;
	assign acc_fire = (state_q == ST_ACC) && (!out_vld_q || result.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (item.valid) state_d = ST_SQ;
			ST_SQ:   if (cnt_q == 6'd4) state_d = ST_ROOT;
			ST_ROOT: if (cnt_q == 6'd31) state_d = ST_CRS;
			ST_CRS:  if (cnt_q == 6'd2) state_d = ST_MR;
			ST_MR:   if (cnt_q == 6'd4) state_d = ST_DIV1;
			ST_DIV1: if (div_done) state_d = inside_q ? ST_MK : ST_MD;
			ST_MD:   if (cnt_q == 6'd4) state_d = ST_DIV2;
			ST_DIV2: if (div_done) state_d = ST_MK;
			ST_MK:   if (cnt_q == 6'd4) state_d = ST_FIN;
			ST_FIN:  state_d = (axis_q == 2'd2) ? ST_ACC : ST_CRS;
			ST_ACC:  if (acc_fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready = 1'b0;
		mul_req.a = '0;
		mul_req.b = '0;
		case (state_q)
			ST_IDLE: item.ready = 1'b1;
			ST_SQ: begin
				case (cnt_q[1:0])
					2'd3: begin
						mul_req.a = {2'b00, r_q};
						mul_req.b = {2'b00, r_q};
					end
					default: begin
						mul_req.a = 33'(d_q[cnt_q[1:0]]);
						mul_req.b = 33'(d_q[cnt_q[1:0]]);
					end
				endcase
			end
			ST_CRS: begin
				if (cnt_q == 6'd0) begin
					mul_req.a = 33'(w_q[ax_n1]);
					mul_req.b = 33'(d_q[ax_n2]);
				end else begin
					mul_req.a = 33'(w_q[ax_n2]);
					mul_req.b = 33'(d_q[ax_n1]);
				end
			end
			ST_MR, ST_MD, ST_MK: begin
				mul_req.a = {1'b0, cnt_q[0] ? opa_q[63:32] : opa_q[31:0]};
				mul_req.b = {1'b0, cnt_q[1] ? opb_q[63:32] : opb_q[31:0]};
			end
			default: begin
				mul_req.a = '0;
			end
		endcase
	end

	assign result.valid = out_vld_q;
	assign result.sum_x = sum_q[0];
	assign result.sum_y = sum_q[1];
	assign result.sum_z = sum_q[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			axis_q <= '0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < 3; i++) sum_q[i] <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_d != state_q) ? 6'd0 : 6'(cnt_q + 6'd1);
			if (state_q == ST_FIN) axis_q <= (axis_q == 2'd2) ? 2'd0 : 2'(axis_q + 2'd1);
			if (acc_fire) begin
				out_vld_q <= 1'b1;
				for (int i = 0; i < 3; i++) begin
					logic signed [42:0] tot;
					tot = (first_q ? 43'sd0 : 43'(sum_q[i])) + 43'(add_q[i]);
					if (tot[42:31] != {12{tot[42]}})
						sum_q[i] <= tot[42] ? 32'sh8000_0000 : 32'sh7fff_ffff;
					else
						sum_q[i] <= tot[31:0];
				end
			end else if (result.valid && result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					for (int i = 0; i < 3; i++) d_q[i] <= d_in[i];
					w_q[0] <= item.spin_x;
					w_q[1] <= item.spin_y;
					w_q[2] <= item.spin_z;
					r_q <= item.core_radius;
					first_q <= item.first;
					d2_q <= 64'd1;
				end
			end
			ST_SQ: begin
				if (cnt_q == 6'd4) begin
					r2_q <= prod_q[63:0];
					inside_q <= d2_q < prod_q[63:0];
					rv_q <= d2_q;
					res_q <= '0;
					bit_q <= 64'd1 << 62;
				end else if (cnt_q != 6'd0) begin
					d2_q <= d2_q + prod_q[63:0];
				end
			end
			ST_ROOT: begin
				if (root_ge) rv_q <= rv_q - root_sum;
				res_q <= root_res;
				bit_q <= bit_q >> 2;
				if (cnt_q == 6'd31) s_q <= root_res[31:0];
			end
			ST_CRS: begin
				if (cnt_q == 6'd1) ca_q <= prod_q;
				if (cnt_q == 6'd2) begin
					neg_q <= crs_diff[66];
					opa_q <= crs_mag;
					opb_q <= 64'(r_q);
					acc_q <= '0;
				end
			end
			ST_MR, ST_MD, ST_MK: begin
				if (cnt_q != 6'd0) acc_q <= acc_nxt;
				if (cnt_q == 6'd4) begin
					if (state_q == ST_MR) den_q <= 64'(s_q) << FRAC_BITS;
					else den_q <= d2_q;
				end
			end
			ST_DIV1, ST_DIV2: begin
				if (div_done) begin
					opa_q <= div_t;
					opb_q <= (state_d == ST_MD) ? r2_q : 64'(KGAIN);
					acc_q <= '0;
				end else begin
					acc_q <= div_nxt;
				end
			end
			ST_FIN: begin
				add_q[axis_q] <= neg_q ? -$signed({1'b0, v_mag}) : $signed({1'b0, v_mag});
			end
			default: begin
				ca_q <= ca_q;
			end
		endcase
	end

	`VPS_ASSERT_NEXT(a_accept_starts, item.valid && item.ready, state_q == ST_SQ,
		"accepted word did not start the squaring pass")
	`VPS_ASSERT_NOW(a_root_nonzero, state_q == ST_CRS, s_q != 32'd0,
		"square root of the biased distance is zero")
	`VPS_ASSERT_NEXT(a_sum_held, result.valid && !result.ready,
		$stable({sum_q[0], sum_q[1], sum_q[2]}), "waiting sum changed")
	`VPS_ASSERT_NOW(a_div_in_mul, div_st, !mul_st,
		"divider and multiplier sequences overlap")
endmodule
